// ===== hw/rtl/sha1e_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1e_pkg
// Shared types, constants and round functions of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1e_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } abcde_t;

  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned NUM_CHAIN  = 5;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned FILL_W     = 6;

  // in_tuser command codes
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0]        PAD_MARK = 8'h80;
  localparam logic [FILL_W-1:0] LEN_POS  = 6'd56;
  localparam logic [FILL_W-1:0] FILL_END = 6'd63;
  localparam logic [2:0]        LAST_IDX = 3'd4;

  localparam word_t IV0 = 32'h6745_2301;
  localparam word_t IV1 = 32'hEFCD_AB89;
  localparam word_t IV2 = 32'h98BA_DCFE;
  localparam word_t IV3 = 32'h1032_5476;
  localparam word_t IV4 = 32'hC3D2_E1F0;

  function automatic word_t round_k(input logic [ROUND_W-1:0] t);
    word_t k;
    if (t < 7'd20) begin
      k = 32'h5A82_7999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9_EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  function automatic word_t round_f(input logic [ROUND_W-1:0] t,
                                    input word_t b, input word_t c, input word_t d);
    word_t f;
    if (t < 7'd20) begin
      f = d ^ (b & (c ^ d));
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (d & (b | c));
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== hw/rtl/sha1e_round.sv =====
// ----------------------------------------------------------------------------
// sha1e_round
// One SHA-1 compression round and the matching message schedule word.
// ----------------------------------------------------------------------------
module sha1e_round (
  input  sha1e_pkg::abcde_t                    cur,
  input  logic [sha1e_pkg::ROUND_W-1:0]        rnd,
  input  sha1e_pkg::word_t                     w0,
  input  sha1e_pkg::word_t                     w2,
  input  sha1e_pkg::word_t                     w8,
  input  sha1e_pkg::word_t                     w13,
  output sha1e_pkg::abcde_t                    nxt,
  output sha1e_pkg::word_t                     w_new
);

  sha1e_pkg::word_t sched;
  sha1e_pkg::word_t temp;

  // schedule word for round t+16, fed into the tail of the window
  assign sched = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {sched[30:0], sched[31]};

  assign temp = {cur.a[26:0], cur.a[31:27]}
              + sha1e_pkg::round_f(rnd, cur.b, cur.c, cur.d)
              + cur.e + sha1e_pkg::round_k(rnd) + w0;

  assign nxt.a = temp;
  assign nxt.b = cur.a;
  assign nxt.c = {cur.b[1:0], cur.b[31:2]};
  assign nxt.d = cur.c;
  assign nxt.e = cur.d;

endmodule

// ===== hw/rtl/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 hash engine: byte stream in, five-beat digest out.
// ----------------------------------------------------------------------------
// Message bytes enter one per beat (in_tuser = 0) and shift into a 64-byte
// block window. The byte that completes a block starts a compression: 80
// rounds through the single round unit, then a fold of the result into the
// chaining words; in_tready is low throughout. A finish beat (in_tuser = 1)
// pads the message one byte per cycle through the same window (0x80, zero
// fill, 64-bit bit length), then compresses; when 56 or more bytes are
// buffered the length needs a block of its own, padded and compressed the
// same way. The digest then leaves as five beats, word 0 first, out_tlast on
// the fifth; after it the engine is back in its initial state.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest 0
  output logic        out_tlast   // last_word
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_COMP = 5'b00100,
    S_ADD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                               state_r, state_nxt;
  logic [sha1e_pkg::FILL_W-1:0]         fill_r, fill_nxt;
  logic [63:0]                          msg_r, msg_nxt;
  logic [63:0]                          len_r, len_nxt;
  logic [sha1e_pkg::ROUND_W-1:0]        rnd_r, rnd_nxt;
  logic [2:0]                           widx_r, widx_nxt;
  logic                                 pad_r, pad_nxt;
  logic                                 mark_r, mark_nxt;
  logic                                 lenok_r, lenok_nxt;
  logic                                 final_r, final_nxt;
  sha1e_pkg::word_t                     blk_r   [sha1e_pkg::BLK_WORDS];
  sha1e_pkg::word_t                     blk_nxt [sha1e_pkg::BLK_WORDS];
  sha1e_pkg::word_t                     chain_r   [sha1e_pkg::NUM_CHAIN];
  sha1e_pkg::word_t                     chain_nxt [sha1e_pkg::NUM_CHAIN];
  sha1e_pkg::abcde_t                    work_r, work_nxt;

  sha1e_pkg::abcde_t                    rnd_out;
  sha1e_pkg::abcde_t                    chain_abcde;
  sha1e_pkg::word_t                     w_new;
  logic [7:0]                           shift_byte;
  logic                                 do_shift;
  logic                                 in_acc;
  logic                                 out_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = out_tvalid && (widx_r == sha1e_pkg::LAST_IDX);
  assign out_tdata  = {5'd0, widx_r, chain_r[widx_r]};
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  assign chain_abcde = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                         d: chain_r[3], e: chain_r[4]};

  sha1e_round u_round (
    .cur   (work_r),
    .rnd   (rnd_r),
    .w0    (blk_r[0]),
    .w2    (blk_r[2]),
    .w8    (blk_r[8]),
    .w13   (blk_r[13]),
    .nxt   (rnd_out),
    .w_new (w_new)
  );

  // byte entering the window: message byte, pad mark, zero fill or length
  always_comb begin
    shift_byte = in_tdata;
    if (state_r == S_PAD) begin
      if (!mark_r) begin
        shift_byte = sha1e_pkg::PAD_MARK;
      end else if (lenok_r && (fill_r >= sha1e_pkg::LEN_POS)) begin
        shift_byte = len_r[63:56];
      end else begin
        shift_byte = 8'd0;
      end
    end
  end

  assign do_shift = (in_acc && (in_tuser == sha1e_pkg::CMD_ABSORB)) || (state_r == S_PAD);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    msg_nxt   = msg_r;
    len_nxt   = len_r;
    rnd_nxt   = rnd_r;
    widx_nxt  = widx_r;
    pad_nxt   = pad_r;
    mark_nxt  = mark_r;
    lenok_nxt = lenok_r;
    final_nxt = final_r;
    work_nxt  = work_r;
    blk_nxt   = blk_r;
    chain_nxt = chain_r;

    // block window: word 0 is the oldest, bytes shift in big-endian
    if (do_shift) begin
      for (int i = 0; i < sha1e_pkg::BLK_WORDS - 1; i++) begin
        blk_nxt[i] = {blk_r[i][23:0], blk_r[i+1][31:24]};
      end
      blk_nxt[sha1e_pkg::BLK_WORDS-1] = {blk_r[sha1e_pkg::BLK_WORDS-1][23:0], shift_byte};
    end else if (state_r == S_COMP) begin
      for (int i = 0; i < sha1e_pkg::BLK_WORDS - 1; i++) begin
        blk_nxt[i] = blk_r[i+1];
      end
      blk_nxt[sha1e_pkg::BLK_WORDS-1] = w_new;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == sha1e_pkg::CMD_FINISH) begin
            len_nxt   = {msg_r[60:0], 3'b000};
            pad_nxt   = 1'b1;
            mark_nxt  = 1'b0;
            lenok_nxt = 1'b0;
            final_nxt = 1'b0;
            state_nxt = S_PAD;
          end else begin
            fill_nxt = fill_r + 1'b1;
            msg_nxt  = msg_r + 64'd1;
            if (fill_r == sha1e_pkg::FILL_END) begin
              work_nxt  = chain_abcde;
              rnd_nxt   = '0;
              state_nxt = S_COMP;
            end
          end
        end
      end
      S_PAD: begin
        fill_nxt = fill_r + 1'b1;
        if (!mark_r) begin
          mark_nxt  = 1'b1;
          // length fits behind the mark only if 8 bytes of room remain
          lenok_nxt = (fill_r < sha1e_pkg::LEN_POS);
        end else if (lenok_r && (fill_r >= sha1e_pkg::LEN_POS)) begin
          len_nxt = {len_r[55:0], 8'd0};
        end
        if (fill_r == sha1e_pkg::FILL_END) begin
          final_nxt = lenok_r;
          work_nxt  = chain_abcde;
          rnd_nxt   = '0;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        work_nxt = rnd_out;
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == sha1e_pkg::ROUND_W'(sha1e_pkg::NUM_ROUNDS - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        chain_nxt[4] = chain_r[4] + work_r.e;
        if (final_r) begin
          widx_nxt  = '0;
          state_nxt = S_OUT;
        end else if (pad_r) begin
          // mark landed too late: the length goes in a block of its own
          lenok_nxt = 1'b1;
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (widx_r == sha1e_pkg::LAST_IDX) begin
            chain_nxt[0] = sha1e_pkg::IV0;
            chain_nxt[1] = sha1e_pkg::IV1;
            chain_nxt[2] = sha1e_pkg::IV2;
            chain_nxt[3] = sha1e_pkg::IV3;
            chain_nxt[4] = sha1e_pkg::IV4;
            fill_nxt  = '0;
            msg_nxt   = '0;
            pad_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            lenok_nxt = 1'b0;
            final_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            widx_nxt = widx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      msg_r      <= '0;
      rnd_r      <= '0;
      widx_r     <= '0;
      pad_r      <= 1'b0;
      mark_r     <= 1'b0;
      lenok_r    <= 1'b0;
      final_r    <= 1'b0;
      chain_r[0] <= sha1e_pkg::IV0;
      chain_r[1] <= sha1e_pkg::IV1;
      chain_r[2] <= sha1e_pkg::IV2;
      chain_r[3] <= sha1e_pkg::IV3;
      chain_r[4] <= sha1e_pkg::IV4;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      msg_r   <= msg_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      lenok_r <= lenok_nxt;
      final_r <= final_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    work_r <= work_nxt;
    blk_r  <= blk_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output sides open at once");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (rnd_r < sha1e_pkg::ROUND_W'(sha1e_pkg::NUM_ROUNDS)))
    else $error("round counter out of range");

  a_final_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && final_r) |-> (fill_r == '0 && mark_r && lenok_r))
    else $error("final block closed without full padding");

  a_digest_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (in_tready && fill_r == '0 && msg_r == '0 && chain_r[0] == sha1e_pkg::IV0))
    else $error("engine not reinitialized after digest");

endmodule

// ===== dv/tb_sha1_hash_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_hash_engine
// Self-checking bench for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
// A queue of byte and finish beats is filled up front: a few directed messages,
// then random messages, most short, some at the padding boundaries and some
// spanning several blocks. A clocked driver feeds the queue with random gaps.
// A clocked monitor takes digest beats with random stalls and compares each
// one against a digest predicted in-bench at the time the input beat went in.
// One long output stall backs the engine up, and some messages wait until all
// earlier digests have drained before they start.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine;

  localparam int   NUM_ITEMS  = 430;
  localparam int   CYC_LIMIT  = 400000;
  localparam int   HOLD_LEN   = 1500;
  localparam int   DRAIN_WAIT = 400;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
    bit         sync;   // wait for all pending digests before this beat
  } byte_item_t;

  typedef struct {
    sha1e_pkg::word_t word;
    logic [2:0]       idx;
    logic             last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [31:0] digest_word, [34:32] word_index
  logic        out_tlast;          // last_word

  sha1_hash_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // predicted engine state
  sha1e_pkg::word_t chain [sha1e_pkg::NUM_CHAIN];
  sha1e_pkg::word_t blk   [sha1e_pkg::BLK_WORDS];
  logic [6:0]       fill;
  logic [63:0]      nbytes;

  byte_item_t   byte_q [$];
  digest_beat_t digest_q [$];
  byte_item_t   cur = '{cmd: 1'b0, data: 8'h00, sync: 1'b0};
  digest_beat_t want;

  bit  busy = 1'b0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  calm = 1'b0;
  bit  hold_on = 1'b0;
  bit  hold_done = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_cnt = 0;
  int  n_rx_beats = 0;
  int  n_err = 0;
  int  cyc = 0;

  function automatic void chain_init();
    chain[0] = sha1e_pkg::IV0;
    chain[1] = sha1e_pkg::IV1;
    chain[2] = sha1e_pkg::IV2;
    chain[3] = sha1e_pkg::IV3;
    chain[4] = sha1e_pkg::IV4;
    fill     = '0;
    nbytes   = '0;
  endfunction

  function automatic void sha1_compress();
    sha1e_pkg::word_t w [16];
    sha1e_pkg::word_t a, b, c, d, e, f, k, wt, tmp;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15];
        wt = {wt[30:0], wt[31]};
        w[t & 15] = wt;
      end
      if (t < 20) begin
        f = d ^ (b & (c ^ d));
        k = 32'h5A82_7999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (t < 60) begin
        f = (b & c) | (d & (b | c));
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void sha1_absorb(logic [7:0] data);
    logic [5:0] pos;
    int         wi, sh;
    pos = fill[5:0];
    wi  = pos >> 2;
    sh  = (3 - pos[1:0]) * 8;
    if (pos[1:0] == 2'd0) blk[wi] = '0;
    blk[wi] |= sha1e_pkg::word_t'(data) << sh;
    nbytes += 64'd1;
    if (pos == sha1e_pkg::FILL_END) begin
      sha1_compress();
      fill = '0;
    end else begin
      fill = {1'b0, pos} + 7'd1;
    end
  endfunction

  function automatic void sha1_finish();
    logic [6:0]       pos;
    int               wi, sh;
    sha1e_pkg::word_t keep;
    logic [63:0]      bits;
    pos  = {1'b0, fill[5:0]};
    wi   = pos[5:2];
    sh   = (3 - pos[1:0]) * 8;
    keep = (pos[1:0] == 2'd0) ? '0 : (32'hFFFF_FFFF << (sh + 8));
    blk[wi] = (blk[wi] & keep) | (sha1e_pkg::word_t'(sha1e_pkg::PAD_MARK) << sh);
    for (int i = wi + 1; i < 16; i++) blk[i] = '0;
    pos = pos + 7'd1;
    // no room left for the length: close this block and pad a fresh one
    if (pos > 7'd56) begin
      sha1_compress();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    bits    = nbytes << 3;
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    sha1_compress();
    for (int i = 0; i < sha1e_pkg::NUM_CHAIN; i++) begin
      digest_q.push_back('{word: chain[i], idx: i[2:0],
                           last: (i[2:0] == sha1e_pkg::LAST_IDX)});
    end
    chain_init();
  endfunction

  function automatic void push_item(logic cmd, logic [7:0] data, bit sync);
    byte_q.push_back('{cmd: cmd, data: data, sync: sync});
  endfunction

  function automatic void add_message(int len, bit sync);
    for (int i = 0; i < len; i++) begin
      push_item(sha1e_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)), sync && (i == 0));
    end
    push_item(sha1e_pkg::CMD_FINISH, 8'($urandom_range(0, 255)), sync && (len == 0));
  endfunction

  // accepted input beat: update the prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_took = 1'b1;
      if (cur.cmd == sha1e_pkg::CMD_FINISH) sha1_finish();
      else sha1_absorb(cur.data);
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        in_took = 1'b0;
        busy    = 1'b0;
        tx_gap  = calm ? 0 : $urandom_range(0, 9);
      end
      if (!busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (byte_q.size() != 0 &&
                     !(byte_q[0].sync && digest_q.size() != 0)) begin
          cur  = byte_q.pop_front();
          busy = 1'b1;
        end
      end
    end
    in_tvalid <= busy;
    in_tuser  <= cur.cmd;
    in_tdata  <= cur.data;
  end

  // digest monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      out_took = 1'b1;
      n_rx_beats++;
      if (digest_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected digest beat: tdata %h last %0b", out_tdata, out_tlast);
        end
      end else begin
        want = digest_q.pop_front();
        if (out_tdata[31:0] !== want.word || out_tdata[34:32] !== want.idx ||
            out_tlast !== want.last) begin
          n_err++;
          if (n_err <= 10) begin
            $display("digest beat mismatch: exp word %h idx %0d last %0b,",
                     want.word, want.idx, want.last,
                     " got word %h idx %0d last %0b",
                     out_tdata[31:0], out_tdata[34:32], out_tlast);
          end
        end
      end
    end
  end

  // output ready with per-beat stalls
  always @(negedge clk) begin
    if (out_took) begin
      out_took = 1'b0;
      rx_gap   = calm ? 0 : $urandom_range(0, 9);
    end
    if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && !hold_on;
    end
  end

  // one long output hold-off while the sender keeps offering beats
  always @(posedge clk) begin
    if (hold_on) begin
      if (hold_cnt == 0) hold_on = 1'b0;
      else hold_cnt--;
    end else if (!hold_done && out_tvalid && n_rx_beats >= 10) begin
      hold_on   = 1'b1;
      hold_done = 1'b1;
      hold_cnt  = HOLD_LEN;
    end
  end

  // cycle limit, plus stretches with no idling on either side
  always @(posedge clk) begin
    cyc++;
    if ($urandom_range(0, 299) == 0) calm = ~calm;
    if (cyc == CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int len;
    int pick;
    int bounds [9] = '{55, 56, 57, 60, 63, 64, 65, 119, 120};
    chain_init();
    // empty message, finish carrying a nonzero ignored byte
    push_item(sha1e_pkg::CMD_FINISH, 8'hFF, 1'b0);
    push_item(sha1e_pkg::CMD_ABSORB, 8'h00, 1'b0);
    push_item(sha1e_pkg::CMD_ABSORB, 8'hFF, 1'b0);
    push_item(sha1e_pkg::CMD_ABSORB, 8'h80, 1'b0);
    push_item(sha1e_pkg::CMD_FINISH, 8'h00, 1'b0);
    push_item(sha1e_pkg::CMD_ABSORB, 8'h61, 1'b0);
    push_item(sha1e_pkg::CMD_ABSORB, 8'h62, 1'b0);
    push_item(sha1e_pkg::CMD_ABSORB, 8'h63, 1'b0);
    push_item(sha1e_pkg::CMD_FINISH, 8'h55, 1'b0);
    push_item(sha1e_pkg::CMD_FINISH, 8'hAA, 1'b0);
    // first random message drains everything before it starts
    add_message(5, 1'b1);
    while (byte_q.size() < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) len = $urandom_range(0, 16);
      else if (pick < 94) len = bounds[$urandom_range(0, 8)];
      else len = $urandom_range(66, 140);
      add_message(len, $urandom_range(0, 7) == 0);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || busy) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_err == 0 && digest_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sha1_hash_engine.f =====
hw/rtl/sha1e_pkg.sv
hw/rtl/sha1e_round.sv
hw/rtl/sha1_hash_engine.sv
dv/tb_sha1_hash_engine.sv
